// ===== hdl/rhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsp_pkg
// Shared widths, constants and the pipeline type of the radial Hermite sprite
// pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rhsp_pkg;

    // Field widths
    localparam int COORD_W = 10;
    localparam int CFG_W   = 4;
    localparam int OUT_W   = 8;

    // Configuration port
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_SIZE_LOG2 = 1'b0;
    localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 4'd5;

    // Default for the largest sprite edge, as log2
    localparam int MAX_SIZE_LOG2_DEF = 10;

    // Width of the shift amount 32 - 2*s
    localparam int SH_W = 6;

    // Square root: radicand is (r^2 / N^2) * 2^32 <= 2^33
    localparam int V_W      = 34;
    localparam int Q_W      = 17;
    localparam int REM_W    = 19;
    localparam int SQ_DIGITS = V_W / 2;
    localparam int SQ_PER    = 3;
    localparam int SQ_STAGES = (SQ_DIGITS + SQ_PER - 1) / SQ_PER;

    // Falloff arithmetic
    localparam int DSQ_W = 33;
    localparam int T_W   = 18;
    localparam int F_W   = 49;
    localparam logic [Q_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [T_W-1:0] THREE_Q16 = 18'd196608;
    localparam logic [F_W-1:0] ONE_Q48   = 49'h1_0000_0000_0000;

    // Square root working set carried down the pipeline
    typedef struct packed {
        logic [V_W-1:0]   v;
        logic [Q_W-1:0]   q;
        logic [REM_W-1:0] rem;
    } t_sqrt_stage;

endpackage

`default_nettype wire

// ===== hdl/rhsp_coord.sv =====
// ----------------------------------------------------------------------------
// rhsp_coord
// Two stages: centered coordinate magnitudes, then squared radius scaled to
// the square root's Q32 radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsp_coord #(
    parameter int MAX_SIZE_LOG2 = rhsp_pkg::MAX_SIZE_LOG2_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [rhsp_pkg::COORD_W-1:0]  i_col,
    input  wire logic [rhsp_pkg::COORD_W-1:0]  i_row,
    input  wire logic [rhsp_pkg::CFG_W-1:0]    i_size_log2,
    input  wire logic                          i_ready_dn,
    output logic                               o_ready_up,
    output logic                               o_valid,
    output rhsp_pkg::t_sqrt_stage              o_data
);

    localparam int SW  = $clog2(MAX_SIZE_LOG2 + 1);
    localparam int AW  = MAX_SIZE_LOG2 + 1;
    localparam int XW  = (rhsp_pkg::COORD_W + 1 > AW) ? rhsp_pkg::COORD_W + 1 : AW;
    localparam int R2W = 2 * AW + 1;

    logic [SW-1:0]                  s_eff;
    logic [rhsp_pkg::COORD_W-1:0]   mask;
    logic [XW-1:0]                  n_full;
    logic [XW-1:0]                  c2;
    logic [XW-1:0]                  r2x;
    logic [AW-1:0]                  n_abs_a;
    logic [AW-1:0]                  n_abs_b;

    logic                           r_valid_a;
    logic [AW-1:0]                  r_abs_a;
    logic [AW-1:0]                  r_abs_b;
    logic [SW-1:0]                  r_s;

    logic [R2W-1:0]                 rsq;
    logic [rhsp_pkg::SH_W-1:0]      shift;
    logic [R2W+31:0]                wide;

    logic                           r_valid_b;
    rhsp_pkg::t_sqrt_stage          r_data_b;
    logic                           ready_a;
    logic                           ready_b;

    assign ready_b    = !r_valid_b || i_ready_dn;
    assign ready_a    = !r_valid_a || ready_b;
    assign o_ready_up = ready_a;
    assign o_valid    = r_valid_b;
    assign o_data     = r_data_b;

    // Clamp the edge exponent and fold the coordinates to the sprite
    always_comb begin
        priority if (i_size_log2 < rhsp_pkg::CFG_W'(1)) begin
            s_eff = SW'(1);
        end else if (i_size_log2 > rhsp_pkg::CFG_W'(MAX_SIZE_LOG2)) begin
            s_eff = SW'(MAX_SIZE_LOG2);
        end else begin
            s_eff = SW'(i_size_log2);
        end
        mask   = rhsp_pkg::COORD_W'(((rhsp_pkg::COORD_W + 1)'(1) << s_eff) - 1'b1);
        n_full = XW'(1) << s_eff;
        c2     = XW'(i_col & mask) << 1;
        r2x    = XW'(i_row & mask) << 1;
        n_abs_a = (c2 >= n_full) ? AW'(c2 - n_full) : AW'(n_full - c2);
        n_abs_b = (r2x >= n_full) ? AW'(r2x - n_full) : AW'(n_full - r2x);
    end

    always_comb begin
        rsq   = R2W'(r_abs_a) * R2W'(r_abs_a) + R2W'(r_abs_b) * R2W'(r_abs_b);
        shift = rhsp_pkg::SH_W'(32 - 2 * int'(r_s));
        wide  = (R2W + 32)'(rsq) << shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_valid_a <= i_valid;
            end
            if (ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_abs_a <= n_abs_a;
            r_abs_b <= n_abs_b;
            r_s     <= s_eff;
        end
        if (ready_b) begin
            r_data_b.v   <= wide[rhsp_pkg::V_W-1:0];
            r_data_b.q   <= '0;
            r_data_b.rem <= '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rhsp_sqrt_step.sv =====
// ----------------------------------------------------------------------------
// rhsp_sqrt_step
// One register stage of the digit-by-digit square root: resolves ITERS
// result bits, starting at radicand digit pair FIRST.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsp_sqrt_step #(
    parameter int FIRST = rhsp_pkg::SQ_DIGITS - 1,
    parameter int ITERS = rhsp_pkg::SQ_PER
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire rhsp_pkg::t_sqrt_stage i_data,
    input  wire logic                  i_ready_dn,
    output logic                       o_ready_up,
    output logic                       o_valid,
    output rhsp_pkg::t_sqrt_stage      o_data
);

    localparam int RW2 = rhsp_pkg::REM_W + 2;

    logic [rhsp_pkg::REM_W-1:0] rem;
    logic [rhsp_pkg::Q_W-1:0]   q;
    logic [RW2-1:0]             rem_w;
    logic [RW2-1:0]             trial;
    logic                       r_valid;
    rhsp_pkg::t_sqrt_stage      r_data;

    assign o_ready_up = !r_valid || i_ready_dn;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    // Bring down one digit pair, try (q << 2) | 1, keep it if it fits
    always_comb begin
        rem   = i_data.rem;
        q     = i_data.q;
        rem_w = '0;
        trial = '0;
        for (int j = 0; j < ITERS; j++) begin
            rem_w = {rem, i_data.v[2 * (FIRST - j) +: 2]};
            trial = RW2'({q, 2'b01});
            if (rem_w >= trial) begin
                rem = rhsp_pkg::REM_W'(rem_w - trial);
                q   = {q[rhsp_pkg::Q_W-2:0], 1'b1};
            end else begin
                rem = rhsp_pkg::REM_W'(rem_w);
                q   = {q[rhsp_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready_up) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready_up) begin
            r_data.v   <= i_data.v;
            r_data.q   <= q;
            r_data.rem <= rem;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rhsp_falloff.sv =====
// ----------------------------------------------------------------------------
// rhsp_falloff
// Three stages: clamp and square the distance, multiply by (3 - 2d), then
// subtract from one and scale to a byte. The last register is the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsp_falloff (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [rhsp_pkg::Q_W-1:0]    i_dist,
    input  wire logic                        i_ready_dn,
    output logic                             o_ready_up,
    output logic                             o_valid,
    output logic [rhsp_pkg::OUT_W-1:0]       o_intensity
);

    localparam int PW = rhsp_pkg::F_W + 1;
    localparam int SW = rhsp_pkg::F_W + 8;

    logic [rhsp_pkg::Q_W-1:0]    d;
    logic [2*rhsp_pkg::Q_W-1:0]  dsq_full;
    logic [PW-1:0]               prod_lo;
    logic [PW-1:0]               prod_hi;
    logic [rhsp_pkg::F_W-1:0]    f;
    logic [SW-1:0]               scaled;

    logic                        r_valid_c;
    logic [rhsp_pkg::DSQ_W-1:0]  r_dsq;
    logic [rhsp_pkg::T_W-1:0]    r_t;
    logic                        r_valid_d;
    logic [rhsp_pkg::F_W-1:0]    r_p;
    logic                        r_valid_e;
    logic [rhsp_pkg::OUT_W-1:0]  r_out;

    logic                        ready_c;
    logic                        ready_d;
    logic                        ready_e;

    assign ready_e     = !r_valid_e || i_ready_dn;
    assign ready_d     = !r_valid_d || ready_e;
    assign ready_c     = !r_valid_c || ready_d;
    assign o_ready_up  = ready_c;
    assign o_valid     = r_valid_e;
    assign o_intensity = r_out;

    always_comb begin
        d        = (i_dist > rhsp_pkg::ONE_Q16) ? rhsp_pkg::ONE_Q16 : i_dist;
        dsq_full = (2 * rhsp_pkg::Q_W)'(d) * (2 * rhsp_pkg::Q_W)'(d);
        // D^2 reaches 2^32 only at D = 1: split off its top bit
        prod_lo  = PW'(r_dsq[31:0]) * PW'(r_t);
        prod_hi  = r_dsq[32] ? (PW'(r_t) << 32) : '0;
        f        = rhsp_pkg::ONE_Q48 - r_p;
        scaled   = (SW'(f) << 8) - SW'(f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
            r_valid_d <= 1'b0;
            r_valid_e <= 1'b0;
        end else begin
            if (ready_c) begin
                r_valid_c <= i_valid;
            end
            if (ready_d) begin
                r_valid_d <= r_valid_c;
            end
            if (ready_e) begin
                r_valid_e <= r_valid_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c) begin
            r_dsq <= dsq_full[rhsp_pkg::DSQ_W-1:0];
            r_t   <= rhsp_pkg::THREE_Q16 - rhsp_pkg::T_W'({d, 1'b0});
        end
        if (ready_d) begin
            r_p <= rhsp_pkg::F_W'(prod_lo + prod_hi);
        end
        if (ready_e) begin
            r_out <= scaled[rhsp_pkg::F_W-1 +: rhsp_pkg::OUT_W];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/radial_hermite_sprite_pixel.sv =====
// ----------------------------------------------------------------------------
// radial_hermite_sprite_pixel
// Per-pixel radial Hermite falloff for an N-by-N sprite, one byte per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present a pixel (i_col, i_row) with i_in_valid; the
//   transaction completes on a clock edge with o_in_stall low. Only the low
//   size_log2 bits of each coordinate are used.
//   Output channel: o_out_valid with o_intensity, the falloff byte that the
//   caller repeats into R, G, B and A; hold it until i_out_stall is low.
//   Configuration: APB register size_log2 at byte address 0 (reset 5, used
//   clamped to 1..MAX_SIZE_LOG2). Write only while no pixel is in flight.
// Throughput: one pixel per cycle while i_out_stall is low, set by the
//   eleven-stage pipeline: two coordinate stages, six square root stages
//   (three result bits each, two in the last), three falloff stages.
// Reset: synchronous, active low; empties the pipeline and loads size_log2.
// Stall: each stage holds only while it is full and the stage after it is
//   holding, so bubbles close up and input stalls only once all stages fill.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_hermite_sprite_pixel #(
    parameter int MAX_SIZE_LOG2 = rhsp_pkg::MAX_SIZE_LOG2_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // pixel input
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [rhsp_pkg::COORD_W-1:0]  i_col,
    input  wire logic [rhsp_pkg::COORD_W-1:0]  i_row,
    // intensity output
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [rhsp_pkg::OUT_W-1:0]         o_intensity,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rhsp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rhsp_pkg::PDATA_W-1:0]  pwdata,
    output logic [rhsp_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int NS = rhsp_pkg::SQ_STAGES;

    logic [rhsp_pkg::CFG_W-1:0] r_size_log2;
    logic                       cfg_wr;

    // Stage links: entry 0 is the coordinate output, entry NS the root
    logic                       sq_valid [NS+1];
    rhsp_pkg::t_sqrt_stage      sq_data  [NS+1];
    logic                       sq_ready [NS+1];

    // Register file: a single register, index taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == rhsp_pkg::REG_SIZE_LOG2)
                  ? rhsp_pkg::PDATA_W'(r_size_log2) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= rhsp_pkg::SIZE_LOG2_RESET;
        end else if (cfg_wr && (paddr[2] == rhsp_pkg::REG_SIZE_LOG2)) begin
            r_size_log2 <= pwdata[rhsp_pkg::CFG_W-1:0];
        end
    end

    // Centered coordinates and the scaled squared radius
    logic coord_ready;

    rhsp_coord #(
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_coord (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_size_log2 (r_size_log2),
        .i_ready_dn  (sq_ready[0]),
        .o_ready_up  (coord_ready),
        .o_valid     (sq_valid[0]),
        .o_data      (sq_data[0])
    );

    assign o_in_stall = !coord_ready;

    // Square root, three result bits per stage, last stage takes the rest
    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        localparam int FIRST = rhsp_pkg::SQ_DIGITS - 1 - g * rhsp_pkg::SQ_PER;
        localparam int ITERS = (FIRST + 1 < rhsp_pkg::SQ_PER) ? FIRST + 1
                                                              : rhsp_pkg::SQ_PER;
        rhsp_sqrt_step #(
            .FIRST (FIRST),
            .ITERS (ITERS)
        ) u_step (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (sq_valid[g]),
            .i_data     (sq_data[g]),
            .i_ready_dn (sq_ready[g+1]),
            .o_ready_up (sq_ready[g]),
            .o_valid    (sq_valid[g+1]),
            .o_data     (sq_data[g+1])
        );
    end

    // Clamp, Hermite polynomial, byte scale
    rhsp_falloff u_falloff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (sq_valid[NS]),
        .i_dist      (sq_data[NS].q),
        .i_ready_dn  (!i_out_stall),
        .o_ready_up  (sq_ready[NS]),
        .o_valid     (o_out_valid),
        .o_intensity (o_intensity)
    );

endmodule

`default_nettype wire

// ===== hdl/rhsp_checker.sv =====
// ----------------------------------------------------------------------------
// rhsp_checker
// Port-level checks of the sprite pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsp_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [rhsp_pkg::OUT_W-1:0]    o_intensity,
    input wire logic                          pready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_intensity))
        else $error("stalled intensity changed");

    // Input backs up only when the whole pipeline is full and held
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while pipeline can advance");

    // Reset empties the pipeline; pready stays high
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && pready)
        else $error("output valid after reset");

endmodule

bind radial_hermite_sprite_pixel rhsp_checker u_rhsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_intensity (o_intensity),
    .pready      (pready)
);

`default_nettype wire
